/* design/scph_pkg.sv */
// Shared types, codes and constants of the serial command packet handler.
`default_nettype none

package scph_pkg;

	localparam int DATA_BYTES  = 4;
	localparam int IDX_W       = $clog2(DATA_BYTES);
	localparam int PKT_BYTES   = 8;
	localparam int BIDX_W      = $clog2(PKT_BYTES);
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'h23;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h25;

	localparam logic [7:0] HDR_NOP    = 8'h00;
	localparam logic [7:0] HDR_SETPIN = 8'h0C;
	localparam logic [7:0] HDR_PING   = 8'h0D;
	localparam logic [7:0] HDR_GETPIN = 8'h82;
	localparam logic [7:0] HDR_ADC    = 8'h83;
	localparam logic [7:0] HDR_PONG   = 8'h84;

	localparam logic [7:0] CHR_P = 8'h50;
	localparam logic [7:0] CHR_O = 8'h4F;
	localparam logic [7:0] CHR_N = 8'h4E;
	localparam logic [7:0] CHR_G = 8'h47;

	localparam logic [1:0] OUT_TX     = 2'd0;
	localparam logic [1:0] OUT_ADC    = 2'd1;
	localparam logic [1:0] OUT_LEVELS = 2'd2;

	localparam logic [1:0] CMD_PINS   = 2'd0;
	localparam logic [1:0] CMD_ADC    = 2'd1;
	localparam logic [1:0] CMD_PACKET = 2'd2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] rx_byte;
		logic [9:0] adc_value;
		logic [7:0] gpio_in;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  tx_byte;
		logic [2:0]  adc_channel;
		logic [7:0]  output_levels;
		logic [15:0] checksum_errors;
		logic [15:0] invalid_headers;
		logic        last;
	} rsp_item_t;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  hdr;
		logic [7:0]  d0;
		logic [7:0]  d1;
		logic [7:0]  d2;
		logic [7:0]  d3;
		logic [7:0]  pins;
		logic [15:0] sum_errs;
		logic [15:0] hdr_errs;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

endpackage

`default_nettype wire

/* design/scph_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface scph_req_if import scph_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface scph_rsp_if import scph_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;
	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* design/scph_queue.sv */
// Small register queue carrying commands from the parser to the sender.
`default_nettype none

module scph_queue import scph_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire cmd_t         push_data,
	input  wire logic         pop,
	output      cmd_t         pop_data,
	output      fifo_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/scph_front.sv */
// Parser: frames bytes, checks the sum, decodes commands and ADC results.
`default_nettype none

module scph_front import scph_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	scph_req_if.sink          req,
	input  wire fifo_status_t qstat,
	output      logic         push,
	output      cmd_t         cmd
);

	localparam logic [1:0] PH_WAIT   = 2'd0;
	localparam logic [1:0] PH_HEADER = 2'd1;
	localparam logic [1:0] PH_DATA   = 2'd2;
	localparam logic [1:0] PH_SUM    = 2'd3;

	logic [7:0]       prev_q, prev_d;
	logic [1:0]       phase_q, phase_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       hdr_q, hdr_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [7:0]       pin_q, pin_d;
	logic [7:0]       lvl_q, lvl_d;
	logic [7:0]       pins_q, pins_d;
	logic [15:0]      bad_sum_q, bad_sum_d;
	logic [15:0]      bad_hdr_q, bad_hdr_d;
	logic             adc_pend_q, adc_pend_d;
	logic [7:0]       adc_byte_q, adc_byte_d;
	logic             accept;
	logic [7:0]       rx;

	assign req.ready = !qstat.full;
	assign accept    = req.valid && req.ready;
	assign rx        = req.item.rx_byte;

	always_comb begin
		prev_d     = prev_q;
		phase_d    = phase_q;
		sum_d      = sum_q;
		hdr_d      = hdr_q;
		idx_d      = idx_q;
		pin_d      = pin_q;
		lvl_d      = lvl_q;
		pins_d     = pins_q;
		bad_sum_d  = bad_sum_q;
		bad_hdr_d  = bad_hdr_q;
		adc_pend_d = adc_pend_q;
		adc_byte_d = adc_byte_q;
		push       = 1'b0;
		cmd        = '0;
		if (accept) begin
			if (req.item.req_type) begin
				if (adc_pend_q) begin
					adc_pend_d = 1'b0;
					push       = 1'b1;
					cmd.kind   = CMD_PACKET;
					cmd.hdr    = HDR_ADC;
					cmd.d0     = adc_byte_q;
					cmd.d1     = req.item.adc_value[7:0];
					cmd.d2     = {6'd0, req.item.adc_value[9:8]};
				end
			end else begin
				prev_d = rx;
				if (prev_q == cfg.sync_first && rx == cfg.sync_second) begin
					phase_d = PH_HEADER;
					sum_d   = prev_q + rx;
				end else begin
					unique case (phase_q)
						PH_WAIT: begin
						end
						PH_HEADER: begin
							hdr_d   = rx;
							sum_d   = sum_q + rx;
							idx_d   = '0;
							phase_d = PH_DATA;
						end
						PH_DATA: begin
							if (idx_q == IDX_W'(0)) begin
								pin_d = rx;
							end
							if (idx_q == IDX_W'(1)) begin
								lvl_d = rx;
							end
							sum_d = sum_q + rx;
							idx_d = idx_q + 1'b1;
							if (idx_q == IDX_W'(DATA_BYTES - 1)) begin
								phase_d = PH_SUM;
							end
						end
						PH_SUM: begin
							phase_d = PH_WAIT;
							if (sum_q != rx) begin
								bad_sum_d = bad_sum_q + 16'd1;
							end else begin
								unique case (hdr_q)
									HDR_NOP: begin
									end
									HDR_SETPIN: begin
										if (pin_q < 8'd8) begin
											if (lvl_q != 8'd0) begin
												pins_d = pins_q | (8'd1 << pin_q[2:0]);
											end else begin
												pins_d = pins_q & ~(8'd1 << pin_q[2:0]);
											end
										end
										push     = 1'b1;
										cmd.kind = CMD_PINS;
									end
									HDR_PING: begin
										push     = 1'b1;
										cmd.kind = CMD_PACKET;
										cmd.hdr  = HDR_PONG;
										cmd.d0   = CHR_P;
										cmd.d1   = CHR_O;
										cmd.d2   = CHR_N;
										cmd.d3   = CHR_G;
									end
									HDR_GETPIN: begin
										push     = 1'b1;
										cmd.kind = CMD_PACKET;
										cmd.hdr  = HDR_GETPIN;
										cmd.d0   = pin_q;
										cmd.d1   = {7'd0, (pin_q < 8'd8) &&
										                  req.item.gpio_in[pin_q[2:0]]};
									end
									HDR_ADC: begin
										adc_pend_d = 1'b1;
										adc_byte_d = pin_q;
										push       = 1'b1;
										cmd.kind   = CMD_ADC;
										cmd.d0     = pin_q;
									end
									default: begin
										bad_hdr_d = bad_hdr_q + 16'd1;
									end
								endcase
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
		cmd.pins     = pins_d;
		cmd.sum_errs = bad_sum_d;
		cmd.hdr_errs = bad_hdr_d;
	end

	always_ff @(posedge clk) begin
		pin_q <= pin_d;
		lvl_q <= lvl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			phase_q    <= PH_WAIT;
			sum_q      <= '0;
			hdr_q      <= '0;
			idx_q      <= '0;
			pins_q     <= '0;
			bad_sum_q  <= '0;
			bad_hdr_q  <= '0;
			adc_pend_q <= 1'b0;
			adc_byte_q <= '0;
		end else begin
			prev_q     <= prev_d;
			phase_q    <= phase_d;
			sum_q      <= sum_d;
			hdr_q      <= hdr_d;
			idx_q      <= idx_d;
			pins_q     <= pins_d;
			bad_sum_q  <= bad_sum_d;
			bad_hdr_q  <= bad_hdr_d;
			adc_pend_q <= adc_pend_d;
			adc_byte_q <= adc_byte_d;
		end
	end

endmodule

`default_nettype wire

/* design/scph_back.sv */
// Response sender: turns queued commands into result transactions.
`default_nettype none

module scph_back import scph_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cfg_t         cfg,
	input  wire cmd_t         head,
	input  wire fifo_status_t qstat,
	output      logic         pop,
	scph_rsp_if.source        rsp
);

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [BIDX_W-1:0] idx_q;
	logic [7:0]        sum_q;
	logic [7:0]        pkt_byte;
	logic              is_last;
	logic              fire;

	always_comb begin
		case (idx_q)
			BIDX_W'(0): pkt_byte = cfg.sync_first;
			BIDX_W'(1): pkt_byte = cfg.sync_second;
			BIDX_W'(2): pkt_byte = cur_q.hdr;
			BIDX_W'(3): pkt_byte = cur_q.d0;
			BIDX_W'(4): pkt_byte = cur_q.d1;
			BIDX_W'(5): pkt_byte = cur_q.d2;
			BIDX_W'(6): pkt_byte = cur_q.d3;
			default:    pkt_byte = sum_q;
		endcase
	end

	assign is_last = (cur_q.kind != CMD_PACKET) || (idx_q == BIDX_W'(PKT_BYTES - 1));
	assign fire    = rsp.valid && rsp.ready;
	assign pop     = !qstat.empty && (!cur_valid_q || (fire && is_last));

	always_comb begin
		rsp.valid                = cur_valid_q;
		rsp.item                 = '0;
		rsp.item.output_levels   = cur_q.pins;
		rsp.item.checksum_errors = cur_q.sum_errs;
		rsp.item.invalid_headers = cur_q.hdr_errs;
		rsp.item.last            = is_last;
		unique case (cur_q.kind)
			CMD_PINS: begin
				rsp.item.out_kind = OUT_LEVELS;
			end
			CMD_ADC: begin
				rsp.item.out_kind    = OUT_ADC;
				rsp.item.adc_channel = cur_q.d0[2:0];
			end
			default: begin
				rsp.item.out_kind = OUT_TX;
				rsp.item.tx_byte  = pkt_byte;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			sum_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			idx_q       <= '0;
			sum_q       <= '0;
		end else if (fire && is_last) begin
			cur_valid_q <= 1'b0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
			sum_q <= sum_q + pkt_byte;
		end
	end

endmodule

`default_nettype wire

/* design/serial_command_packet_handler_unit.sv */
// Top level of the serial command packet handler.
// A request transaction is taken in every cycle while the command queue has room.
// The first result of a command is registered in the command queue and then in the sender; a response
// packet then drives one byte per cycle while the receiver is ready, eight bytes in all.
// Reset clears the parser state but for the stored pin and level bytes, the pins, counters and the queue;
// the start bytes return to 0x23 and 0x25.
`default_nettype none

module serial_command_packet_handler_unit import scph_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	scph_req_if.sink                   req,
	scph_rsp_if.source                 rsp,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t         cfg_q;
	logic         push;
	logic         pop;
	cmd_t         cmd;
	cmd_t         head;
	fifo_status_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= SYNC_FIRST_RST;
			cfg_q.sync_second <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_SYNC_FIRST) begin
				cfg_q.sync_first <= cfg_data;
			end else if (cfg_index == REG_SYNC_SECOND) begin
				cfg_q.sync_second <= cfg_data;
			end
		end
	end

	scph_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.qstat  (qstat),
		.push   (push),
		.cmd    (cmd)
	);

	scph_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cmd),
		.pop       (pop),
		.pop_data  (head),
		.status    (qstat)
	);

	scph_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

/* bench/tb_serial_command_packet_handler_unit.sv */
// Self-checking testbench for the serial command packet handler with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_serial_command_packet_handler_unit;
	import scph_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 24;

	typedef enum logic [1:0] {AWAIT_SYNC, TAKE_HEADER, TAKE_DATA, TAKE_SUM} parse_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	scph_req_if req_ch ();
	scph_rsp_if rsp_ch ();

	serial_command_packet_handler_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	req_item_t req_backlog[$];
	rsp_item_t predicted_rsp[$];
	int        mismatches;
	int        queued;
	int        cycles;

	// Predictor state and its copy of the start-byte registers.
	logic [7:0]  sync_a, sync_b;
	logic [7:0]  last_rx;
	parse_t      phase;
	logic [7:0]  run_sum;
	logic [7:0]  pkt_hdr;
	logic [7:0]  pkt_data[DATA_BYTES];
	logic [2:0]  data_idx;
	logic [7:0]  out_pins;
	logic [15:0] bad_sums;
	logic [15:0] bad_hdrs;
	logic        adc_armed;
	logic [7:0]  adc_req_byte;
	rsp_item_t   staged;
	bit          have_staged;

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			report($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// Results are held back by one so that the last one of an input can be marked.
	task automatic stage_result(input logic [1:0] kind, input logic [7:0] tx, input logic [2:0] ch);
		if (have_staged)
			predicted_rsp.push_back(staged);
		staged.out_kind        = kind;
		staged.tx_byte         = tx;
		staged.adc_channel     = ch;
		staged.output_levels   = out_pins;
		staged.checksum_errors = bad_sums;
		staged.invalid_headers = bad_hdrs;
		staged.last            = 1'b0;
		have_staged            = 1'b1;
	endtask

	task automatic stage_reply(input logic [7:0] hdr, input logic [7:0] d0, input logic [7:0] d1,
			input logic [7:0] d2, input logic [7:0] d3);
		logic [7:0] bytes[7];
		logic [7:0] sum;
		bytes = '{sync_a, sync_b, hdr, d0, d1, d2, d3};
		sum   = 8'h00;
		for (int i = 0; i < 7; i++) begin
			sum = sum + bytes[i];
			stage_result(OUT_TX, bytes[i], 3'd0);
		end
		stage_result(OUT_TX, sum, 3'd0);
	endtask

	task automatic decode_packet(input logic [7:0] gpio);
		logic [7:0] pin;
		logic       level;
		pin = pkt_data[0];
		case (pkt_hdr)
			HDR_NOP: ;
			HDR_SETPIN: begin
				if (pin < 8) begin
					if (pkt_data[1] != 8'h00)
						out_pins[pin[2:0]] = 1'b1;
					else
						out_pins[pin[2:0]] = 1'b0;
				end
				stage_result(OUT_LEVELS, 8'h00, 3'd0);
			end
			HDR_PING: stage_reply(HDR_PONG, CHR_P, CHR_O, CHR_N, CHR_G);
			HDR_GETPIN: begin
				level = (pin < 8) ? gpio[pin[2:0]] : 1'b0;
				stage_reply(HDR_GETPIN, pin, {7'd0, level}, 8'h00, 8'h00);
			end
			HDR_ADC: begin
				adc_armed    = 1'b1;
				adc_req_byte = pin;
				stage_result(OUT_ADC, 8'h00, pin[2:0]);
			end
			default: bad_hdrs = bad_hdrs + 16'd1;
		endcase
	endtask

	task automatic predict_responses(input req_item_t it);
		logic [7:0] b, prev;
		if (it.req_type) begin
			if (adc_armed) begin
				adc_armed = 1'b0;
				stage_reply(HDR_ADC, adc_req_byte, it.adc_value[7:0], {6'd0, it.adc_value[9:8]},
					8'h00);
			end
		end else begin
			b       = it.rx_byte;
			prev    = last_rx;
			last_rx = b;
			if (prev == sync_a && b == sync_b) begin
				phase   = TAKE_HEADER;
				run_sum = prev + b;
			end else begin
				case (phase)
					TAKE_HEADER: begin
						pkt_hdr  = b;
						run_sum  = run_sum + b;
						data_idx = 3'd0;
						phase    = TAKE_DATA;
					end
					TAKE_DATA: begin
						pkt_data[data_idx[IDX_W-1:0]] = b;
						run_sum  = run_sum + b;
						data_idx = data_idx + 3'd1;
						if (data_idx >= DATA_BYTES)
							phase = TAKE_SUM;
					end
					TAKE_SUM: begin
						if (run_sum == b)
							decode_packet(it.gpio_in);
						else
							bad_sums = bad_sums + 16'd1;
						phase = AWAIT_SYNC;
					end
					default: ;
				endcase
			end
		end
		if (have_staged) begin
			staged.last = 1'b1;
			predicted_rsp.push_back(staged);
			have_staged = 1'b0;
		end
	endtask

	function automatic int pause_len(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 6));
	endfunction

	// Request driver.
	int tx_gap;
	bit tx_calm;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				predict_responses(req_ch.item);
			if (!req_ch.valid || req_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					req_ch.valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.item <= req_backlog.pop_front();
					if ($urandom_range(0, 23) == 0)
						tx_calm = !tx_calm;
					tx_gap <= pause_len(tx_calm);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor.
	int        rx_stall;
	bit        rx_calm;
	rsp_item_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (predicted_rsp.size() == 0) begin
					report("response transaction with nothing expected");
				end else begin
					want = predicted_rsp.pop_front();
					check_field("out_kind", rsp_ch.item.out_kind, want.out_kind);
					check_field("tx_byte", rsp_ch.item.tx_byte, want.tx_byte);
					check_field("adc_channel", rsp_ch.item.adc_channel, want.adc_channel);
					check_field("output_levels", rsp_ch.item.output_levels, want.output_levels);
					check_field("checksum_errors", rsp_ch.item.checksum_errors,
						want.checksum_errors);
					check_field("invalid_headers", rsp_ch.item.invalid_headers,
						want.invalid_headers);
					check_field("last", rsp_ch.item.last, want.last);
				end
				if ($urandom_range(0, 23) == 0)
					rx_calm = !rx_calm;
				rx_stall = pause_len(rx_calm);
			end
			if (rx_stall > 0) begin
				rx_stall = rx_stall - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b);
		req_item_t it;
		it.req_type  = 1'b0;
		it.rx_byte   = b;
		it.adc_value = 10'($urandom);
		it.gpio_in   = 8'($urandom);
		req_backlog.push_back(it);
		queued++;
	endtask

	task automatic queue_adc(input logic [9:0] v);
		req_item_t it;
		it.req_type  = 1'b1;
		it.rx_byte   = 8'($urandom);
		it.adc_value = v;
		it.gpio_in   = 8'($urandom);
		req_backlog.push_back(it);
		queued++;
	endtask

	task automatic queue_packet(input logic [7:0] hdr, input logic [7:0] d0, input logic [7:0] d1,
			input logic [7:0] d2, input logic [7:0] d3, input bit corrupt);
		logic [7:0] sum;
		sum = sync_a + sync_b + hdr + d0 + d1 + d2 + d3;
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		queue_byte(sync_a);
		queue_byte(sync_b);
		queue_byte(hdr);
		queue_byte(d0);
		queue_byte(d1);
		queue_byte(d2);
		queue_byte(d3);
		queue_byte(sum);
	endtask

	task automatic write_sync(input logic [7:0] first, input logic [7:0] second);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data  <= first;
		@(posedge clk);
		cfg_index <= REG_SYNC_SECOND;
		cfg_data  <= second;
		@(posedge clk);
		cfg_we <= 1'b0;
		sync_a = first;
		sync_b = second;
	endtask

	// The stimulus holds off here until all requests are sent and every expected transaction has arrived.
	task automatic drain();
		while (!(req_backlog.size() == 0 && !req_ch.valid && predicted_rsp.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_traffic(input int n);
		int         start;
		logic [7:0] hdr, pin, state;
		int         cut;
		start = queued;
		while (queued - start < n) begin
			case ($urandom_range(0, 19))
				15, 16: queue_adc(10'($urandom));
				17: queue_byte(8'($urandom));
				18: begin
					queue_byte(sync_a);
					queue_byte(sync_b);
					cut = $urandom_range(1, 5);
					for (int i = 0; i < cut; i++)
						queue_byte(8'($urandom));
				end
				19: begin
					queue_byte(sync_a);
					queue_byte(($urandom_range(0, 1) == 0) ? sync_a : 8'($urandom));
				end
				default: begin
					case ($urandom_range(0, 9))
						0: hdr = HDR_NOP;
						1, 2: hdr = HDR_SETPIN;
						3: hdr = HDR_PING;
						4, 5: hdr = HDR_GETPIN;
						6, 7: hdr = HDR_ADC;
						8: hdr = HDR_PONG;
						default: hdr = 8'($urandom);
					endcase
					pin   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
					state = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom);
					queue_packet(hdr, pin, state, 8'($urandom), 8'($urandom),
						$urandom_range(0, 7) == 0);
				end
			endcase
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		req_ch.valid = 1'b0;
		req_ch.item  = '0;
		rsp_ch.ready = 1'b0;
		mismatches   = 0;
		queued       = 0;
		cycles       = 0;
		tx_gap       = 0;
		rx_stall     = 0;
		tx_calm      = 1'b0;
		rx_calm      = 1'b0;
		have_staged  = 1'b0;
		sync_a       = SYNC_FIRST_RST;
		sync_b       = SYNC_SECOND_RST;
		last_rx      = 8'h00;
		phase        = AWAIT_SYNC;
		run_sum      = 8'h00;
		pkt_hdr      = 8'h00;
		data_idx     = 3'd0;
		out_pins     = 8'h00;
		bad_sums     = 16'd0;
		bad_hdrs     = 16'd0;
		adc_armed    = 1'b0;
		adc_req_byte = 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a conversion result with no request, requests and results, a restart
		// in the middle of a packet, pin limits, a bad checksum and an unknown header.
		queue_adc(10'h3FF);
		queue_packet(HDR_ADC, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_adc(10'h3FF);
		queue_adc(10'h000);
		queue_byte(sync_a);
		queue_byte(sync_b);
		queue_byte(HDR_SETPIN);
		queue_byte(8'h03);
		queue_packet(HDR_PING, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_packet(HDR_SETPIN, 8'h07, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		queue_packet(HDR_SETPIN, 8'hFF, 8'h01, 8'h00, 8'h00, 1'b0);
		queue_packet(HDR_GETPIN, 8'h08, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_packet(HDR_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_packet(HDR_PONG, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
		queue_packet(HDR_NOP, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		drain();

		write_sync(8'h00, 8'hFF);
		random_traffic(66);
		drain();
		write_sync(8'hFF, 8'h00);
		random_traffic(66);
		drain();
		write_sync(8'($urandom), 8'($urandom));
		random_traffic(66);
		drain();
		write_sync(8'h5A, 8'h5A);
		random_traffic(66);
		drain();
		write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
		random_traffic(66);
		drain();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
